### rtl/rwcf_pkg.sv
`default_nettype none
package rwcf_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;
  localparam int PIX_W          = 24;
  localparam int SUM_W          = 18;

  localparam logic [2:0]  MODE_RST   = 3'd0;
  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [11:0] HEIGHT_RST = 12'd480;

  typedef enum logic [2:0] {
    MODE_BOX    = 3'd0,
    MODE_GAUSS3 = 3'd1,
    MODE_GAUSS5 = 3'd2,
    MODE_SOBX   = 3'd3,
    MODE_SOBY   = 3'd4,
    MODE_GRAY   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  // Window: first index is the row slot (0 newest row), second the column (0 newest).
  typedef logic [4:0][4:0][PIX_W-1:0] win_t;

  function automatic logic signed [7:0] wgt(mode_t m, int s, int j);
    logic signed [7:0] g3 [5];
    logic signed [7:0] g5 [5];
    logic signed [7:0] r;
    g3[0] = 8'sd1; g3[1] = 8'sd2; g3[2] = 8'sd1; g3[3] = 8'sd0; g3[4] = 8'sd0;
    g5[0] = 8'sd1; g5[1] = 8'sd4; g5[2] = 8'sd6; g5[3] = 8'sd4; g5[4] = 8'sd1;
    r = 8'sd0;
    case (m)
      MODE_BOX:    r = (s < 3 && j < 3) ? 8'sd1 : 8'sd0;
      MODE_GAUSS3: r = 8'(g3[s] * g3[j]);
      MODE_GAUSS5: r = 8'(g5[s] * g5[j]);
      MODE_SOBX:   r = (s < 3 && j < 3) ? 8'((1 - s) * g3[j]) : 8'sd0;
      MODE_SOBY:   r = (s < 3 && j < 3) ? 8'((1 - j) * g3[s]) : 8'sd0;
      default:     r = 8'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/rwcf_kernel.sv
`default_nettype none
module rwcf_kernel (
  input  wire logic                          clk,
  input  wire logic                          adv,
  input  wire rwcf_pkg::mode_t               mode,
  input  wire rwcf_pkg::win_t                win,
  output logic [rwcf_pkg::PIX_W-1:0]         res
);

  localparam int SW = rwcf_pkg::SUM_W;

  logic signed [SW-1:0] rs_r   [5][3];
  logic signed [SW-1:0] rs_nxt [5][3];
  logic signed [SW-1:0] tot    [3];
  logic signed [SW+1:0] sob;
  logic [31:0]          boxp   [3];
  logic [7:0]           ch     [3];

  // Window taps with a zero weight are left out of the sum.
  always_comb begin
    logic signed [7:0] wv;
    wv = '0;
    for (int s = 0; s < 5; s++) begin
      for (int c = 0; c < 3; c++) begin
        rs_nxt[s][c] = '0;
        for (int j = 0; j < 5; j++) begin
          wv = rwcf_pkg::wgt(mode, s, j);
          if (wv != 8'sd0) begin
            rs_nxt[s][c] = rs_nxt[s][c] +
              SW'($signed({{(SW-8){wv[7]}}, wv}) *
                  $signed({{(SW-8){1'b0}}, win[s][j][c*8 +: 8]}));
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rs_r <= rs_nxt;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tot[c] = rs_r[0][c] + rs_r[1][c] + rs_r[2][c] + rs_r[3][c] + rs_r[4][c];
      boxp[c] = 32'(unsigned'(tot[c])) * 32'd7282;
      case (mode)
        rwcf_pkg::MODE_BOX:    ch[c] = boxp[c][23:16];
        rwcf_pkg::MODE_GAUSS3: ch[c] = tot[c][11:4];
        default:               ch[c] = tot[c][15:8];
      endcase
    end
    sob = (SW+2)'(tot[0]) + (SW+2)'(tot[1]) + (SW+2)'(tot[2]);
    if (mode == rwcf_pkg::MODE_SOBX || mode == rwcf_pkg::MODE_SOBY) begin
      res = (sob >= (SW+2)'(387)) ? {3{8'hff}} : '0;
    end else begin
      res = {ch[2], ch[1], ch[0]};
    end
  end

endmodule
`default_nettype wire

### rtl/rgb_window_convolution_filter.sv
`default_nettype none
// Streaming BGR image filter: box 3x3, Gauss 3x3, Gauss 5x5, Sobel X/Y threshold or grayscale.
// One pixel is accepted per clock and results leave at the same rate when the output is not
// stalled. A line memory with one column word per pixel position (the four previous rows)
// is read and written back once per pixel, feeding a 5x5 window of registers. In window modes
// a result appears for each pixel once border rows plus border pixels have arrived, and the
// tail of the frame is drained by flush requests; grayscale answers every pixel. Pixels within
// the border of a frame edge pass through unchanged.
module rgb_window_convolution_filter #(
  parameter int MAX_WIDTH  = rwcf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rwcf_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // blue_in, green_in, red_in
  input  wire logic        in_tuser,   // cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // blue_out, green_out, red_out
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int DWA = $clog2(MAX_WIDTH + 1);
  localparam int DWB = $clog2(MAX_HEIGHT + 1);
  localparam int DW0 = (DWA > DWB) ? DWA : DWB;
  localparam int DW  = (DW0 > 12) ? DW0 : 12;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int PW  = rwcf_pkg::PIX_W;

  logic [2:0]  mode_r;
  logic [11:0] width_r;
  logic [11:0] height_r;
  logic        cfg_wr;
  rwcf_pkg::reg_idx_t cfg_idx;

  rwcf_pkg::mode_t mode;
  logic [DW-1:0]   eff_w;
  logic [DW-1:0]   eff_h;
  logic [DW-1:0]   bw;

  logic [DW-1:0] in_col_r,  in_col_nxt;
  logic [DW:0]   in_row_r,  in_row_nxt;
  logic [DW-1:0] out_col_r, out_col_nxt;
  logic [DW-1:0] out_row_r, out_row_nxt;

  logic adv;
  logic acc;
  logic act;
  logic emit;
  logic gray_emit;
  logic border;
  logic last;
  logic done;
  logic pos_ge;

  logic [3*PW/6-1:0] unused_w;

  logic [4*PW-1:0] line_mem [MAX_WIDTH];
  logic [4*PW-1:0] rdata_r;

  logic          s1_v_r, s1_emit_r, s1_gray_r, s1_border_r, s1_last_r;
  logic [PW-1:0] s1_pix_r;
  logic [CW-1:0] s1_addr_r;
  logic          s2_emit_r, s2_gray_r, s2_border_r, s2_last_r;
  logic [PW-1:0] s2_pix_r;
  logic          s3_emit_r, s3_gray_r, s3_border_r, s3_last_r;
  logic [PW-1:0] s3_pix_r, s3_ctr_r;

  rwcf_pkg::win_t win_r;
  logic [4:0][PW-1:0] col_in;
  logic [PW-1:0] kres;
  logic [9:0]    gsum;
  logic [19:0]   gprod;
  logic [7:0]    gval;

  logic [PW-1:0] out_data_r;
  logic          out_last_r, out_valid_r;

  assign unused_w = '0;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = rwcf_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_idx != rwcf_pkg::REG_NONE;

  always_comb begin
    case (cfg_idx)
      rwcf_pkg::REG_MODE:   cfg_prdata = {29'd0, mode_r};
      rwcf_pkg::REG_WIDTH:  cfg_prdata = {20'd0, width_r};
      rwcf_pkg::REG_HEIGHT: cfg_prdata = {20'd0, height_r};
      default:              cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= rwcf_pkg::MODE_RST;
      width_r  <= rwcf_pkg::WIDTH_RST;
      height_r <= rwcf_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rwcf_pkg::REG_MODE:   mode_r   <= cfg_pwdata[2:0];
        rwcf_pkg::REG_WIDTH:  width_r  <= cfg_pwdata[11:0];
        rwcf_pkg::REG_HEIGHT: height_r <= cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  assign mode  = (mode_r > 3'd5) ? rwcf_pkg::MODE_GRAY : rwcf_pkg::mode_t'(mode_r);
  assign eff_w = (width_r < 12'd5) ? DW'(5) :
                 (DW'(width_r) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(width_r);
  assign eff_h = (height_r < 12'd5) ? DW'(5) :
                 (DW'(height_r) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(height_r);
  assign bw    = (mode == rwcf_pkg::MODE_GAUSS5) ? DW'(2) : DW'(1);

  // Input side: position counters and result scheduling.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign acc       = in_tvalid && adv;

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    act       = 1'b0;
    emit      = 1'b0;
    gray_emit = 1'b0;
    border    = 1'b0;
    last      = 1'b0;
    done      = in_row_r >= {1'b0, eff_h};
    pos_ge    = in_row_r > {1'b0, bw} || (in_row_r == {1'b0, bw} && in_col_r >= bw);
    if (acc) begin
      if (mode == rwcf_pkg::MODE_GRAY) begin
        if (!in_tuser) begin
          gray_emit = 1'b1;
          last = in_row_r >= {1'b0, eff_h - DW'(1)} && in_col_r >= eff_w - DW'(1);
          if (last) begin
            in_col_nxt = '0;
            in_row_nxt = '0;
            out_col_nxt = '0;
            out_row_nxt = '0;
          end else if (in_col_r + DW'(1) >= eff_w) begin
            in_col_nxt = '0;
            in_row_nxt = in_row_r + (DW+1)'(1);
          end else begin
            in_col_nxt = in_col_r + DW'(1);
          end
        end
      end else begin
        act = done || !in_tuser;
        if (act) begin
          if (in_col_r + DW'(1) >= eff_w) begin
            in_col_nxt = '0;
            in_row_nxt = in_row_r + (DW+1)'(1);
          end else begin
            in_col_nxt = in_col_r + DW'(1);
          end
          emit = pos_ge;
        end
        if (emit) begin
          border = out_row_r < bw || out_row_r >= eff_h - bw ||
                   out_col_r < bw || out_col_r >= eff_w - bw;
          last = out_row_r == eff_h - DW'(1) && out_col_r == eff_w - DW'(1);
          if (last) begin
            in_col_nxt = '0;
            in_row_nxt = '0;
            out_col_nxt = '0;
            out_row_nxt = '0;
          end else if (out_col_r + DW'(1) >= eff_w) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + DW'(1);
          end else begin
            out_col_nxt = out_col_r + DW'(1);
          end
        end
      end
    end
    if (cfg_wr) begin
      in_col_nxt = '0;
      in_row_nxt = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // Line memory: each word holds the four previous rows of one column.
  always_ff @(posedge clk) begin
    if (adv) begin
      rdata_r <= line_mem[in_col_r[CW-1:0]];
      if (s1_v_r) begin
        line_mem[s1_addr_r] <= {rdata_r[3*PW-1:0], s1_pix_r};
      end
    end
  end

  assign col_in = {rdata_r, s1_pix_r};

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      for (int s = 0; s < 5; s++) begin
        for (int j = 4; j > 0; j--) begin
          win_r[s][j] <= win_r[s][j-1];
        end
        win_r[s][0] <= col_in[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s1_emit_r <= 1'b0;
      s1_gray_r <= 1'b0;
      s2_emit_r <= 1'b0;
      s2_gray_r <= 1'b0;
      s3_emit_r <= 1'b0;
      s3_gray_r <= 1'b0;
    end else if (adv) begin
      s1_v_r    <= act;
      s1_emit_r <= emit;
      s1_gray_r <= gray_emit;
      s2_emit_r <= s1_emit_r;
      s2_gray_r <= s1_gray_r;
      s3_emit_r <= s2_emit_r;
      s3_gray_r <= s2_gray_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix_r    <= in_tdata;
      s1_addr_r   <= in_col_r[CW-1:0];
      s1_border_r <= border;
      s1_last_r   <= last;
      s2_pix_r    <= s1_pix_r;
      s2_border_r <= s1_border_r;
      s2_last_r   <= s1_last_r;
      s3_pix_r    <= s2_pix_r;
      s3_border_r <= s2_border_r;
      s3_last_r   <= s2_last_r;
      s3_ctr_r    <= (mode == rwcf_pkg::MODE_GAUSS5) ? win_r[2][2] : win_r[1][1];
    end
  end

  rwcf_kernel u_kernel (
    .clk  (clk),
    .adv  (adv),
    .mode (mode),
    .win  (win_r),
    .res  (kres)
  );

  assign gsum  = 10'(s3_pix_r[7:0]) + 10'(s3_pix_r[15:8]) + 10'(s3_pix_r[23:16]);
  assign gprod = 20'(gsum) * 20'd683;
  assign gval  = gprod[18:11];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_emit_r || s3_gray_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_last_r <= s3_last_r;
      if (s3_gray_r) begin
        out_data_r <= {gval, gval, gval};
      end else if (s3_border_r) begin
        out_data_r <= s3_ctr_r;
      end else begin
        out_data_r <= kres;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r | PW'(unused_w);
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
